[rtl/upcps_pkg.sv]
`timescale 1ns / 1ps

package upcps_pkg;

    localparam int BLOCK_SYMBOLS = 64;
    localparam int SPREAD_FACTOR = 4;
    localparam int UPSAMPLE      = 8;
    localparam int TRUNC_SPAN    = 4;

    localparam int NCHIPS    = BLOCK_SYMBOLS * SPREAD_FACTOR;
    localparam int TERMS     = 2 * TRUNC_SPAN + 1;
    localparam int TAP_COUNT = TERMS * UPSAMPLE;

    localparam int CHIP_AW = (NCHIPS > 1) ? $clog2(NCHIPS) : 1;
    localparam int TAP_AW  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int PHASE_W = (UPSAMPLE > 1) ? $clog2(UPSAMPLE) : 1;
    localparam int TERM_W  = (TERMS > 1) ? $clog2(TERMS) : 1;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 36;
    localparam int OUT_W    = 20;
    localparam int SIDX_W   = 11;
    localparam int FRAC_W   = 15;

    typedef enum logic [1:0] {
        CMD_WRITE_TAP  = 2'd0,
        CMD_WRITE_CHIP = 2'd1,
        CMD_COMPUTE    = 2'd2,
        CMD_UNUSED     = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last_term;
        logic                last_phase;
        logic [SIDX_W-1:0]   sample_index;
    } t_stage;

endpackage

[rtl/upcps_if.sv]
`timescale 1ns / 1ps

interface upcps_in_if;
    import upcps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [7:0]                 position;
    logic signed [SAMPLE_W-1:0] tap_value;
    logic signed [SAMPLE_W-1:0] chip_value;
    logic signed [SAMPLE_W-1:0] pilot_value;

    modport source (
        output valid, cmd, position, tap_value, chip_value, pilot_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, position, tap_value, chip_value, pilot_value,
        output ready
    );
endinterface

interface upcps_out_if;
    import upcps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] shaped_data;
    logic signed [OUT_W-1:0] shaped_pilot;
    logic [SIDX_W-1:0]       sample_index;
    logic                    last;

    modport source (
        output valid, shaped_data, shaped_pilot, sample_index, last,
        input  ready
    );

    modport sink (
        input  valid, shaped_data, shaped_pilot, sample_index, last,
        output ready
    );
endinterface

[rtl/upcps_ram.sv]
`timescale 1ns / 1ps

module upcps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/upsampled_circular_pulse_shaper_core.sv]
`timescale 1ns / 1ps
// Transmit pulse shaper with a data and a pilot channel.
// The input channel takes one command word at a time. A tap write or a chip
// pair write produces no output word. A compute word for chip index k
// produces UPSAMPLE output words, one per phase, each carrying the shaped
// data and pilot samples, the upsampled sample index and a last flag on the
// final phase of the chip period.
// Each output sample is a sum of 2*TRUNC_SPAN+1 products per channel. The
// tap memory and the chip memory each give one entry per cycle while the
// pipeline is not stalled, so one term is added per cycle: a compute word
// holds the input side busy until the last term of its final phase is issued.
// The read, multiply and accumulate stages form a short pipeline behind one
// output register. When the receiver stalls and a finished sample has
// nowhere to go, the whole pipeline and the memory reads hold in place.
// Reset clears the control state only; taps and chips must be written
// before a compute word reads them.

module upsampled_circular_pulse_shaper_core
    import upcps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    upcps_in_if.sink    i_in,
    upcps_out_if.source o_out
);

    t_state r_state;
    t_state n_state;

    logic [CHIP_AW-1:0] r_k;
    logic [CHIP_AW-1:0] r_base_ca;
    logic [CHIP_AW-1:0] r_ca;
    logic [TAP_AW-1:0]  r_ta;
    logic [PHASE_W-1:0] r_phase;
    logic [TERM_W-1:0]  r_term;

    t_stage r_s1;
    t_stage r_s2;

    logic signed [PROD_W-1:0]   r_prod_d;
    logic signed [PROD_W-1:0]   r_prod_p;
    logic signed [ACC_W-1:0]    r_acc_d;
    logic signed [ACC_W-1:0]    r_acc_p;

    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out_data;
    logic signed [OUT_W-1:0]    r_out_pilot;
    logic [SIDX_W-1:0]          r_out_sidx;
    logic                       r_out_last;

    logic accept;
    logic in_ready;
    logic issue;
    logic en;
    logic tap_we;
    logic chip_we;
    logic start;
    logic term_done;
    logic phase_done;

    logic [CHIP_AW-1:0]         start_ca;
    logic [SIDX_W-1:0]          issue_sidx;
    logic signed [SAMPLE_W-1:0] tap_rd;
    logic [2*SAMPLE_W-1:0]      chip_rd;
    logic signed [ACC_W-1:0]    sum_d;
    logic signed [ACC_W-1:0]    sum_p;

    function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-FRAC_W-1:0] sh;
        logic signed [ACC_W-FRAC_W-1:0] hi;
        logic signed [ACC_W-FRAC_W-1:0] lo;
        sh = a[ACC_W-1:FRAC_W];
        hi = (ACC_W-FRAC_W)'((1 << (OUT_W - 1)) - 1);
        lo = -hi - (ACC_W-FRAC_W)'(1);
        if (sh > hi) begin
            return hi[OUT_W-1:0];
        end else if (sh < lo) begin
            return lo[OUT_W-1:0];
        end else begin
            return sh[OUT_W-1:0];
        end
    endfunction

    assign accept     = i_in.valid && in_ready;
    assign en         = !(r_s2.valid && r_s2.last_term && r_out_valid && !o_out.ready);
    assign term_done  = (r_term == TERM_W'(TERMS - 1));
    assign phase_done = (r_phase == PHASE_W'(UPSAMPLE - 1));

    assign tap_we  = accept && (i_in.cmd == CMD_WRITE_TAP)
                     && (int'(i_in.position) < TAP_COUNT);
    assign chip_we = accept && (i_in.cmd == CMD_WRITE_CHIP)
                     && (int'(i_in.position) < NCHIPS);
    assign start   = accept && (i_in.cmd == CMD_COMPUTE)
                     && (int'(i_in.position) < NCHIPS);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (en && term_done && phase_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_RUN:   issue    = en;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = in_ready;

    always_comb begin
        int t;
        t = int'(i_in.position[CHIP_AW-1:0]) + TRUNC_SPAN;
        if (t >= NCHIPS) begin
            t = t - NCHIPS;
        end
        start_ca = CHIP_AW'(t);
    end

    assign issue_sidx = SIDX_W'(int'(r_k) * UPSAMPLE + int'(r_phase));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_term  <= '0;
        end else if (start) begin
            r_phase <= '0;
            r_term  <= '0;
        end else if (issue) begin
            if (term_done) begin
                r_term  <= '0;
                r_phase <= phase_done ? '0 : r_phase + PHASE_W'(1);
            end else begin
                r_term  <= r_term + TERM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_k       <= i_in.position[CHIP_AW-1:0];
            r_base_ca <= start_ca;
            r_ca      <= start_ca;
            r_ta      <= '0;
        end else if (issue) begin
            if (term_done) begin
                r_ca <= r_base_ca;
                r_ta <= TAP_AW'(int'(r_phase) + 1);
            end else begin
                r_ca <= (r_ca == '0) ? CHIP_AW'(NCHIPS - 1) : r_ca - CHIP_AW'(1);
                r_ta <= r_ta + TAP_AW'(UPSAMPLE);
            end
        end
    end

    upcps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAP_COUNT)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (i_in.position[TAP_AW-1:0]),
        .i_wdata (i_in.tap_value),
        .i_re    (en),
        .i_raddr (r_ta),
        .o_rdata (tap_rd)
    );

    upcps_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (NCHIPS)
    ) u_chip_ram (
        .i_clk   (i_clk),
        .i_we    (chip_we),
        .i_waddr (i_in.position[CHIP_AW-1:0]),
        .i_wdata ({i_in.pilot_value, i_in.chip_value}),
        .i_re    (en),
        .i_raddr (r_ca),
        .o_rdata (chip_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (en) begin
            r_s1.valid        <= issue;
            r_s1.first        <= (r_term == '0);
            r_s1.last_term    <= term_done;
            r_s1.last_phase   <= phase_done;
            r_s1.sample_index <= issue_sidx;
            r_s2              <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_d <= tap_rd * $signed(chip_rd[SAMPLE_W-1:0]);
            r_prod_p <= tap_rd * $signed(chip_rd[2*SAMPLE_W-1:SAMPLE_W]);
        end
    end

    assign sum_d = (r_s2.first ? ACC_W'(0) : r_acc_d) + ACC_W'(r_prod_d);
    assign sum_p = (r_s2.first ? ACC_W'(0) : r_acc_p) + ACC_W'(r_prod_p);

    always_ff @(posedge i_clk) begin
        if (en && r_s2.valid) begin
            r_acc_d <= sum_d;
            r_acc_p <= sum_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_s2.valid && r_s2.last_term) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2.valid && r_s2.last_term) begin
            r_out_data  <= scale_sat(sum_d);
            r_out_pilot <= scale_sat(sum_p);
            r_out_sidx  <= r_s2.sample_index;
            r_out_last  <= r_s2.last_phase;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.shaped_data  = r_out_data;
    assign o_out.shaped_pilot = r_out_pilot;
    assign o_out.sample_index = r_out_sidx;
    assign o_out.last         = r_out_last;

endmodule
